// File: rtl/kmsd_pkg.sv
`timescale 1ns / 1ps

package kmsd_pkg;

  // Default matrix geometry.
  localparam int ROWS_DEF = 4;
  localparam int COLS_DEF = 3;

  // Fixed field widths.
  localparam int LEVELS_W   = 3;
  localparam int CODE_W     = 4;
  localparam int ROW_OUT_W  = 2;
  localparam int DRIVE_W    = 4;
  localparam int DBL_W      = 4;
  localparam int HIST_W     = 8;
  localparam int MAP_ENTRIES = 12;
  localparam int KEYMAP_W   = MAP_ENTRIES * CODE_W;
  localparam int MAX_RES    = 3;
  localparam int CFG_IDX_W  = 2;

  // Register reset values.
  localparam logic [DBL_W-1:0]    DEBOUNCE_RESET = 4'd4;
  localparam logic [KEYMAP_W-1:0] KEYMAP_RESET   = 48'hC0A9_8765_4321;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_LEN = 2'd0,
    CFG_KEY_MAP      = 2'd1
  } cfg_reg_t;

endpackage

// File: rtl/keypad_matrix_scan_debounce_top.sv
`timescale 1ns / 1ps
// The results of a scan tick are registered and presented in the cycle after its transfer.
// A tick yields one to three results, shown one per cycle from the result buffer
// while out_ready is high; the next tick is taken in the cycle its predecessor's
// last result leaves.
// Reset (synchronous, active low) clears all key histories, key states, the row index
// and the result buffer control, and loads debounce_len = 4 and the default key map.
module keypad_matrix_scan_debounce_top #(
  parameter int ROWS = kmsd_pkg::ROWS_DEF,
  parameter int COLS = kmsd_pkg::COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Scan tick input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kmsd_pkg::LEVELS_W-1:0] in_column_levels,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_key_valid,
  output logic [kmsd_pkg::CODE_W-1:0]   out_key_code,
  output logic [kmsd_pkg::ROW_OUT_W-1:0] out_scanned_row,
  output logic [kmsd_pkg::DRIVE_W-1:0]  out_row_drive,
  output logic                          out_last,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kmsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kmsd_pkg::KEYMAP_W-1:0] cfg_data
);

  import kmsd_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int ROW_V = COLS * HIST_W;

  // Configuration registers.
  logic [DBL_W-1:0]    debounce_len_r;
  logic [KEYMAP_W-1:0] key_map_r;

  // Per-row key state: each row holds the histories and pressed flags of its keys.
  logic [ROW_V-1:0] hist_r  [ROWS];
  logic [COLS-1:0]  press_r [ROWS];
  logic [RW-1:0]    row_idx_r;

  // Result buffer for the tick being delivered.
  logic                busy_r;
  logic                any_r;
  logic [1:0]          res_cnt_r;
  logic [1:0]          res_pos_r;
  logic [CODE_W-1:0]   res_code_r [MAX_RES];
  logic [ROW_OUT_W-1:0] res_row_r;
  logic [DRIVE_W-1:0]  res_drive_r;

  // Combinational results of the current tick.
  logic [ROW_V-1:0]    hist_nxt;
  logic [COLS-1:0]     press_nxt;
  logic [1:0]          cnt_nxt;
  logic [CODE_W-1:0]   code_nxt [MAX_RES];
  logic [RW-1:0]       row_nxt;
  logic [DRIVE_W-1:0]  drive_nxt;
  logic [HIST_W-1:0]   mask;
  logic [COLS-1:0]     levels;
  logic                in_xfer;
  logic                out_xfer;

  assign levels    = COLS'(in_column_levels);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  // A new tick may enter while the final result of the previous one is taken.
  assign in_ready  = !busy_r || (out_ready && out_last);

  // Debounce window: the low debounce_len bits, clamped to 1..8.
  always_comb begin
    logic [DBL_W-1:0] n;
    n = debounce_len_r;
    if (n == '0) begin
      n = DBL_W'(1);
    end else if (n > DBL_W'(HIST_W)) begin
      n = DBL_W'(HIST_W);
    end
    for (int b = 0; b < HIST_W; b++) begin
      mask[b] = (DBL_W'(b) < n);
    end
  end

  // Shift the sampled levels into the row's histories, update the key states
  // and collect the codes of up to three newly pressed keys in column order.
  always_comb begin
    logic [ROW_V-1:0]  row_hist;
    logic [COLS-1:0]   row_press;
    logic [HIST_W-1:0] h;
    logic              full;
    logic              empty;
    int                idx;
    row_hist  = hist_r[row_idx_r];
    row_press = press_r[row_idx_r];
    hist_nxt  = row_hist;
    press_nxt = row_press;
    cnt_nxt   = 2'd0;
    idx       = 0;
    for (int k = 0; k < MAX_RES; k++) begin
      code_nxt[k] = '0;
    end
    for (int c = 0; c < COLS; c++) begin
      h     = {row_hist[c*HIST_W +: HIST_W-1], levels[c]};
      full  = ((h & mask) == mask);
      empty = ((h & mask) == '0);
      hist_nxt[c*HIST_W +: HIST_W] = h;
      if (full) begin
        press_nxt[c] = 1'b1;
      end else if (empty) begin
        press_nxt[c] = 1'b0;
      end
      if (full && !row_press[c] && (cnt_nxt < 2'(MAX_RES))) begin
        idx = int'(row_idx_r) * COLS + c;
        for (int e = 0; e < MAP_ENTRIES; e++) begin
          if (idx == e) begin
            code_nxt[cnt_nxt] = key_map_r[e*CODE_W +: CODE_W];
          end
        end
        cnt_nxt = cnt_nxt + 2'd1;
      end
    end
  end

  // Next row and its one-hot drive; rows beyond the drive width drive nothing.
  always_comb begin
    logic [7:0] next8;
    if (row_idx_r == RW'(ROWS - 1)) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_idx_r + RW'(1);
    end
    next8 = 8'(row_nxt);
    for (int b = 0; b < DRIVE_W; b++) begin
      drive_nxt[b] = (next8 == 8'(b));
    end
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_len_r <= DEBOUNCE_RESET;
      key_map_r      <= KEYMAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE_LEN: debounce_len_r <= cfg_data[DBL_W-1:0];
        CFG_KEY_MAP:      key_map_r      <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Key state and row pointer advance on each accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        hist_r[r]  <= '0;
        press_r[r] <= '0;
      end
      row_idx_r <= '0;
    end else if (in_xfer) begin
      hist_r[row_idx_r]  <= hist_nxt;
      press_r[row_idx_r] <= press_nxt;
      row_idx_r          <= row_nxt;
    end
  end

  // Result buffer control. A tick with no new press still produces one result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      any_r     <= 1'b0;
      res_cnt_r <= 2'd0;
      res_pos_r <= 2'd0;
    end else if (in_xfer) begin
      busy_r    <= 1'b1;
      any_r     <= (cnt_nxt != 2'd0);
      res_cnt_r <= (cnt_nxt == 2'd0) ? 2'd1 : cnt_nxt;
      res_pos_r <= 2'd0;
    end else if (out_xfer) begin
      if (out_last) begin
        busy_r <= 1'b0;
      end else begin
        res_pos_r <= res_pos_r + 2'd1;
      end
    end
  end

  // Result payload, loaded with each accepted tick.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int k = 0; k < MAX_RES; k++) begin
        res_code_r[k] <= code_nxt[k];
      end
      res_row_r   <= ROW_OUT_W'(row_idx_r);
      res_drive_r <= drive_nxt;
    end
  end

  assign out_valid       = busy_r;
  assign out_key_valid   = any_r;
  assign out_key_code    = any_r ? res_code_r[res_pos_r] : '0;
  assign out_scanned_row = res_row_r;
  assign out_row_drive   = res_drive_r;
  assign out_last        = (res_pos_r == res_cnt_r - 2'd1);

  // A new tick overlaps the buffer only as its final result leaves.
  a_overlap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && busy_r) |-> (out_ready && out_last))
    else $error("tick accepted while earlier results were pending");

  // The read position never runs past the number of buffered results.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (res_pos_r < res_cnt_r) && (res_cnt_r != 2'd0))
    else $error("result position out of range");

  // A result that reports no press is the only result of its tick.
  a_idle_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_key_valid) |-> (out_last && out_key_code == '0))
    else $error("empty result not single or carries a code");

  // The scan pointer moves to the following row exactly when a tick is taken.
  a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (row_idx_r == $past(row_nxt)) && $onehot0(out_row_drive))
    else $error("row pointer did not advance correctly");

endmodule
